@@ sv/smenum_pkg.sv @@
// Shared types, widths and helpers for the stable matching enumerator.
// No dependencies; every other file imports this package.
package smenum_pkg;

	localparam int GROUP_SIZE_DEF = 3;
	localparam int MAX_GROUP      = 4;
	localparam int RANK_W         = 18;
	localparam int ASSIGN_W       = 6;
	localparam int NUM_W          = 3;
	localparam int MAX_RESULTS    = 6;
	localparam int QUEUE_DEPTH    = 2;

	typedef struct packed {
		logic [RANK_W-1:0] man_ranks;
		logic [RANK_W-1:0] woman_ranks;
	} ranks_t;

	typedef struct packed {
		logic                found;
		logic [ASSIGN_W-1:0] assignment;
		logic [NUM_W-1:0]    match_number;
		logic                last_match;
	} result_t;

	// Rank held by 'who' for 'whom'; bits beyond the table read as zero.
	function automatic logic [1:0] rank_at(input logic [RANK_W-1:0] tbl, input int who,
		input int whom, input int n);
		int                sh;
		logic [RANK_W-1:0] shifted;
		sh = 2 * (n * who + whom);
		shifted = tbl >> sh;
		return shifted[1:0];
	endfunction

endpackage

@@ sv/smenum_front.sv @@
// Input side: accepts preference instances and holds them in a short queue.
// Depends on smenum_pkg for ranks_t and the queue depth.
module smenum_front import smenum_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [RANK_W-1:0] man_ranks,
	input  logic [RANK_W-1:0] woman_ranks,
	output logic              q_valid,
	input  logic              q_pop,
	output ranks_t            q_data
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	ranks_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   fill_q;
	logic            push;
	logic            pop;

	assign item_ready = (fill_q != CW'(QUEUE_DEPTH));
	assign q_valid    = (fill_q != '0);
	assign push       = item_valid && item_ready;
	assign pop        = q_pop && q_valid;
	assign q_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{man_ranks: man_ranks, woman_ranks: woman_ranks};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

@@ sv/smenum_search.sv @@
// Back end: backtracking search over assignments, one placement tried per cycle unless stalled.
// Depends on smenum_pkg for ranks_t, result_t and rank_at.
module smenum_search import smenum_pkg::*; #(
	parameter int GROUP_SIZE = GROUP_SIZE_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_valid,
	output logic    q_pop,
	input  ranks_t  q_data,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res_data
);

	localparam int IW = $clog2(GROUP_SIZE);
	localparam int CW = IW + 1;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DONE   = 2'd2;

	logic [1:0]          state_q;
	logic [RANK_W-1:0]   man_q;
	logic [RANK_W-1:0]   woman_q;
	logic [IW-1:0]       pa_q [GROUP_SIZE];
	logic [IW-1:0]       m_q;
	logic [CW-1:0]       cand_q;
	logic [NUM_W-1:0]    count_q;
	logic                pend_v_q;
	logic [ASSIGN_W-1:0] pend_asg_q;
	logic [NUM_W-1:0]    pend_num_q;

	logic [IW-1:0]          wm;
	logic [IW-1:0]          wj;
	logic [IW-1:0]          prev;
	logic                   stable;
	logic                   exhausted;
	logic                   at_last;
	logic                   collect;
	logic                   stall;
	logic [2*MAX_GROUP-1:0] packed_full;

	assign exhausted = (cand_q >= CW'(GROUP_SIZE));
	assign at_last   = (m_q == IW'(GROUP_SIZE - 1));
	assign wm        = cand_q[IW-1:0];
	assign collect   = (state_q == ST_SEARCH) && !exhausted && stable && at_last &&
		(count_q < NUM_W'(MAX_RESULTS));
	assign stall     = collect && pend_v_q && !res_ready;
	assign q_pop     = (state_q == ST_IDLE);

	// Check the trial placement of man m against every earlier man.
	always_comb begin
		stable = 1'b1;
		wj = '0;
		for (int j = 0; j < GROUP_SIZE; j++) begin
			if (j < int'(m_q)) begin
				wj = pa_q[j];
				if (wj == wm) begin
					stable = 1'b0;
				end
				if (rank_at(man_q, int'(m_q), int'(wj), GROUP_SIZE) <
					rank_at(man_q, int'(m_q), int'(wm), GROUP_SIZE) &&
					rank_at(woman_q, int'(wj), int'(m_q), GROUP_SIZE) <
					rank_at(woman_q, int'(wj), j, GROUP_SIZE)) begin
					stable = 1'b0;
				end
				if (rank_at(woman_q, int'(wm), j, GROUP_SIZE) <
					rank_at(woman_q, int'(wm), int'(m_q), GROUP_SIZE) &&
					rank_at(man_q, j, int'(wm), GROUP_SIZE) <
					rank_at(man_q, j, int'(wj), GROUP_SIZE)) begin
					stable = 1'b0;
				end
			end
		end
	end

	always_comb begin
		packed_full = '0;
		prev = '0;
		for (int k = 0; k < GROUP_SIZE; k++) begin
			packed_full[2*k +: 2] = (k == int'(m_q)) ? 2'(wm) : 2'(pa_q[k]);
			if (k == int'(m_q) - 1) begin
				prev = pa_q[k];
			end
		end
	end

	// Flush the held matching when a newer one arrives; at the end send it flagged last, or a not-found result.
	always_comb begin
		res_valid = 1'b0;
		res_data  = '{found: 1'b1, assignment: pend_asg_q, match_number: pend_num_q,
			last_match: 1'b0};
		case (state_q)
			ST_SEARCH: begin
				res_valid = collect && pend_v_q;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (pend_v_q) begin
					res_data.last_match = 1'b1;
				end else begin
					res_data = '{found: 1'b0, assignment: '0, match_number: '0,
						last_match: 1'b1};
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			man_q   <= q_data.man_ranks;
			woman_q <= q_data.woman_ranks;
		end
		if (state_q == ST_SEARCH && !exhausted && !stall) begin
			pa_q[m_q] <= wm;
		end
		if (collect && !stall) begin
			pend_asg_q <= packed_full[ASSIGN_W-1:0];
			pend_num_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_q      <= '0;
			cand_q   <= '0;
			count_q  <= '0;
			pend_v_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q  <= ST_SEARCH;
						m_q      <= '0;
						cand_q   <= '0;
						count_q  <= '0;
						pend_v_q <= 1'b0;
					end
				end
				ST_SEARCH: begin
					if (exhausted) begin
						if (m_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							m_q    <= m_q - 1'b1;
							cand_q <= CW'(prev) + 1'b1;
						end
					end else if (!stall) begin
						if (!stable) begin
							cand_q <= cand_q + 1'b1;
						end else if (at_last) begin
							cand_q <= cand_q + 1'b1;
							if (collect) begin
								count_q  <= count_q + 1'b1;
								pend_v_q <= 1'b1;
							end
						end else begin
							m_q    <= m_q + 1'b1;
							cand_q <= '0;
						end
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/smenum_out.sv @@
// Output register between the search engine and the result channel.
// Depends on smenum_pkg for result_t and field widths.
module smenum_out import smenum_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_valid,
	output logic                res_ready,
	input  result_t             res_data,
	output logic                result_valid,
	input  logic                result_ready,
	output logic                found,
	output logic [ASSIGN_W-1:0] assignment,
	output logic [NUM_W-1:0]    match_number,
	output logic                last_match
);

	logic    valid_q;
	result_t data_q;

	assign res_ready    = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign found        = data_q.found;
	assign assignment   = data_q.assignment;
	assign match_number = data_q.match_number;
	assign last_match   = data_q.last_match;

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			data_q <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

endmodule

@@ sv/stable_matching_enumerator.sv @@
// Stable matching enumerator: for each preference instance on the item channel,
// emits every stable one-to-one matching on the result channel.
// Item channel: item_valid/item_ready with man_ranks and woman_ranks (2-bit
// ranks, lower preferred). Result channel: result_valid/result_ready with found,
// assignment (woman per man, man 0 lowest), match_number and last_match.
// One instance gives one to six results; the final one carries last_match. With
// no stable matching a single result with found low is sent.
// Each instance is loaded from the queue, then the search tries one placement or
// takes one backtrack step per cycle while the result channel does not stall it,
// then hands over the final result; the search sequencer sets the rate.
// A two-entry input queue takes new instances while a search runs.
// A stalled receiver holds the output register; the search then pauses only
// when it must hand over a newer matching or its final result. Reset empties the
// queue, idles the search and drops any pending result.
module stable_matching_enumerator import smenum_pkg::*; #(
	parameter int GROUP_SIZE = GROUP_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic [RANK_W-1:0]   man_ranks,
	input  logic [RANK_W-1:0]   woman_ranks,
	output logic                result_valid,
	input  logic                result_ready,
	output logic                found,
	output logic [ASSIGN_W-1:0] assignment,
	output logic [NUM_W-1:0]    match_number,
	output logic                last_match
);

	logic    q_valid;
	logic    q_pop;
	ranks_t  q_data;
	logic    res_valid;
	logic    res_ready;
	result_t res_data;

	smenum_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.man_ranks   (man_ranks),
		.woman_ranks (woman_ranks),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_data      (q_data)
	);

	smenum_search #(
		.GROUP_SIZE (GROUP_SIZE)
	) u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_data    (q_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	smenum_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res_data     (res_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.found        (found),
		.assignment   (assignment),
		.match_number (match_number),
		.last_match   (last_match)
	);

endmodule
